### rtl/rpfa_pkg.sv
`default_nettype none

package rpfa_pkg;

    // Sizes of the managed address space.
    localparam int ADDR_W      = 28;
    localparam int PAGE_SHIFT  = 12;
    localparam int PAGE_W      = ADDR_W - PAGE_SHIFT;
    localparam int NUM_PAGES   = 65536;
    localparam int IDX_W       = $clog2(NUM_PAGES);
    localparam int DEPTH_W     = IDX_W + 1;
    localparam int COUNT_WIDTH = 16;
    localparam int LOW_W       = 16;
    localparam int VAL_W       = 16;
    localparam int TALLY_W     = 17;

    // Command codes.
    localparam logic [2:0] CMD_ALLOC = 3'd0;
    localparam logic [2:0] CMD_FREE  = 3'd1;
    localparam logic [2:0] CMD_INC   = 3'd2;
    localparam logic [2:0] CMD_DEC   = 3'd3;
    localparam logic [2:0] CMD_SET   = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;

    // Status codes.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_EMPTY   = 2'd1;
    localparam logic [1:0] STAT_BADADDR = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [ADDR_W-1:0] phys_addr;
        logic [VAL_W-1:0]  ref_value;
    } t_req;

    typedef struct packed {
        logic [1:0]             status;
        logic [ADDR_W-1:0]      page_addr;
        logic [COUNT_WIDTH-1:0] page_refs;
        logic [TALLY_W-1:0]     free_count;
        logic [TALLY_W-1:0]     used_count;
    } t_rsp;

endpackage

`default_nettype wire

### rtl/refcounted_page_frame_allocator_top.sv
// A request is registered on accept and its result on execute, which waits while
// an older result is not taken. Due to the read-modify-write of the count and
// free-stack memories (registered reads), a new request waits for the last one.
// Reset: synchronous, active low. After reset a clearing pass writes zero to all
// 65536 count entries, one per cycle, before the first request is accepted.
`default_nettype none

module refcounted_page_frame_allocator_top (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire rpfa_pkg::t_req            i_in,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output rpfa_pkg::t_rsp                 o_out,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [rpfa_pkg::LOW_W-1:0] i_cfg_data
);
    import rpfa_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
    localparam logic [DEPTH_W-1:0]     DEPTH_MX = DEPTH_W'(NUM_PAGES);
    localparam logic [IDX_W-1:0]       IDX_LAST = IDX_W'(NUM_PAGES - 1);

    // Memories.
    logic [COUNT_WIDTH-1:0] mem_cnt [NUM_PAGES];
    logic [IDX_W-1:0]       mem_stk [NUM_PAGES];

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_clr_idx;
    logic [DEPTH_W-1:0]     r_depth, n_depth;
    logic [LOW_W-1:0]       r_lowest;
    t_req                   r_req;
    logic [COUNT_WIDTH-1:0] r_cnt_rd;
    logic [IDX_W-1:0]       r_stk_rd;
    logic                   r_out_valid;
    t_rsp                   r_out, n_out;

    logic                   in_fire, exec_fire, clr_active;
    logic                   cnt_we;
    logic [IDX_W-1:0]       cnt_wa;
    logic [COUNT_WIDTH-1:0] cnt_wd;
    logic                   stk_we;
    logic [IDX_W-1:0]       stk_rd_idx;
    logic [PAGE_W-1:0]      page;
    logic [PAGE_SHIFT-1:0]  offs;
    logic                   page_oob;
    logic [COUNT_WIDTH-1:0] cnt_dec;
    logic [DEPTH_W-1:0]     managed;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_idx == IDX_LAST) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_EXEC;
            S_EXEC:  if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // State machine outputs.
    always_comb begin
        o_in_ready = 1'b0;
        exec_fire  = 1'b0;
        clr_active = 1'b0;
        unique case (r_state)
            S_CLEAR: clr_active = 1'b1;
            S_IDLE:  o_in_ready = 1'b1;
            S_EXEC:  exec_fire  = !r_out_valid || i_out_ready;
            default: clr_active = 1'b0;
        endcase
    end

    assign in_fire    = i_in_valid && o_in_ready;
    assign stk_rd_idx = IDX_W'(r_depth - DEPTH_W'(1));

    // Fields of the request under execution.
    assign page     = r_req.phys_addr[ADDR_W-1:PAGE_SHIFT];
    assign offs     = r_req.phys_addr[PAGE_SHIFT-1:0];
    assign page_oob = {1'b0, page} >= DEPTH_MX;
    assign cnt_dec  = (r_cnt_rd != '0) ? r_cnt_rd - COUNT_WIDTH'(1) : '0;
    assign managed  = ({1'b0, r_lowest} < DEPTH_MX) ? DEPTH_MX - {1'b0, r_lowest} : '0;

    // Execute: new count, stack update and the result.
    always_comb begin
        n_depth = r_depth;
        cnt_we  = 1'b0;
        cnt_wa  = IDX_W'(page);
        cnt_wd  = r_cnt_rd;
        stk_we  = 1'b0;
        n_out   = '0;
        case (r_req.cmd) inside
            CMD_ALLOC: begin
                if (r_depth == '0) begin
                    n_out.status = STAT_EMPTY;
                end else begin
                    n_depth         = r_depth - DEPTH_W'(1);
                    cnt_we          = 1'b1;
                    cnt_wa          = r_stk_rd;
                    cnt_wd          = COUNT_WIDTH'(1);
                    n_out.page_addr = ADDR_W'({r_stk_rd, {PAGE_SHIFT{1'b0}}});
                    n_out.page_refs = COUNT_WIDTH'(1);
                end
            end
            CMD_FREE: begin
                if (offs != '0 || page < r_lowest || page_oob) begin
                    n_out.status = STAT_BADADDR;
                end else begin
                    cnt_we = 1'b1;
                    cnt_wd = cnt_dec;
                    if (cnt_dec == '0 && r_depth == DEPTH_MX) begin
                        n_out.status = STAT_FULL;
                    end else begin
                        if (cnt_dec == '0) begin
                            stk_we  = 1'b1;
                            n_depth = r_depth + DEPTH_W'(1);
                        end
                        n_out.page_refs = cnt_dec;
                    end
                end
            end
            CMD_INC, CMD_DEC, CMD_SET, CMD_READ: begin
                if (page_oob) begin
                    n_out.status = STAT_BADADDR;
                end else begin
                    cnt_we = 1'b1;
                    case (r_req.cmd)
                        CMD_INC: cnt_wd = (r_cnt_rd != CNT_MAX)
                                          ? r_cnt_rd + COUNT_WIDTH'(1) : CNT_MAX;
                        CMD_DEC: cnt_wd = cnt_dec;
                        CMD_SET: cnt_wd = ({1'b0, r_req.ref_value} < (VAL_W+1)'(CNT_MAX))
                                          ? COUNT_WIDTH'(r_req.ref_value) : CNT_MAX;
                        default: cnt_wd = r_cnt_rd;
                    endcase
                    n_out.page_refs = cnt_wd;
                end
            end
            default: n_out.status = STAT_OK;
        endcase
        n_out.free_count = TALLY_W'(n_depth);
        n_out.used_count = (managed >= n_depth) ? TALLY_W'(managed - n_depth) : '0;
    end

    // Count memory: clearing pass, then read on accept and write on execute.
    always_ff @(posedge i_clk) begin
        if (clr_active) begin
            mem_cnt[r_clr_idx] <= '0;
        end else if (exec_fire && cnt_we) begin
            mem_cnt[cnt_wa] <= cnt_wd;
        end
        if (in_fire) begin
            r_cnt_rd <= mem_cnt[i_in.phys_addr[PAGE_SHIFT +: IDX_W]];
        end
    end

    // Free-stack memory: pop read on accept, push write on execute.
    always_ff @(posedge i_clk) begin
        if (exec_fire && stk_we) begin
            mem_stk[r_depth[IDX_W-1:0]] <= IDX_W'(page);
        end
        if (in_fire) begin
            r_stk_rd <= mem_stk[stk_rd_idx];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req <= i_in;
        end
        if (exec_fire) begin
            r_out <= n_out;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_depth     <= '0;
            r_lowest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clr_active) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (exec_fire) begin
                r_depth <= n_depth;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_lowest <= i_cfg_data;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The stack never holds more entries than there are pages.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_MX)
        else $error("free stack depth beyond page count");

    // No request is taken while the clearing pass runs.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_active |-> !o_in_ready)
        else $error("request accepted during clearing pass");

    // An accepted request reaches execution in the next cycle.
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_EXEC))
        else $error("accepted request did not start execution");

    // A failed allocation reports a zero page address.
    a_empty_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == STAT_EMPTY) |-> (o_out.page_addr == '0))
        else $error("failed allocation with nonzero address");

endmodule

`default_nettype wire

### dv/testbench.sv
`default_nettype none

module testbench;
    import rpfa_pkg::*;

    // Command codes the block does not use; they must leave all state alone.
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_req             i_in        = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_rsp             o_out;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [LOW_W-1:0] i_cfg_data  = '0;

    // Allocator state as the testbench tracks it.
    logic [COUNT_WIDTH-1:0] page_counts [NUM_PAGES];
    logic [IDX_W-1:0]       free_pages_stack [NUM_PAGES];
    logic [DEPTH_W-1:0]     stack_top  = '0;
    logic [TALLY_W-1:0]     free_total = '0;
    logic [LOW_W-1:0]       low_page   = '0;

    // Outcomes of accepted requests, oldest first.
    t_rsp page_outcomes [$];
    t_rsp last_outcome;
    int   fail_count = 0;

    // Traffic shaping knobs.
    bit          tx_gaps_on    = 1'b0;
    int          tx_burst_left = 0;
    logic        rx_stall_on   = 1'b0;
    logic        rx_hold       = 1'b0;
    logic [15:0] rx_pattern    = 16'hFFFF;
    logic [3:0]  rx_phase      = '0;

    refcounted_page_frame_allocator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The result side stalls on a rotating pattern, or holds off completely on request.
    always @(posedge i_clk) begin
        rx_phase    <= rx_phase + 4'd1;
        i_out_ready <= !rx_hold && (!rx_stall_on || rx_pattern[rx_phase]);
    end

    // Apply one command to the tracked state and return the result it must produce.
    function automatic t_rsp apply_page_cmd(input t_req r);
        int unsigned           pg;
        int unsigned           managed;
        logic [PAGE_SHIFT-1:0] offs;
        logic [IDX_W-1:0]      popped;
        t_rsp                  o;
        o    = '0;
        pg   = 32'(r.phys_addr[ADDR_W-1:PAGE_SHIFT]);
        offs = r.phys_addr[PAGE_SHIFT-1:0];
        case (r.cmd) inside
            CMD_ALLOC: begin
                if (stack_top == '0) begin
                    o.status = STAT_EMPTY;
                end else begin
                    stack_top = stack_top - DEPTH_W'(1);
                    popped = free_pages_stack[stack_top[IDX_W-1:0]];
                    page_counts[popped] = COUNT_WIDTH'(1);
                    if (free_total != '0) begin
                        free_total = free_total - TALLY_W'(1);
                    end
                    o.page_addr = ADDR_W'(popped) << PAGE_SHIFT;
                    o.page_refs = COUNT_WIDTH'(1);
                end
            end
            CMD_FREE: begin
                if (offs != '0 || pg < 32'(low_page) || pg >= NUM_PAGES) begin
                    o.status = STAT_BADADDR;
                end else begin
                    if (page_counts[pg] != '0) begin
                        page_counts[pg] = page_counts[pg] - COUNT_WIDTH'(1);
                    end
                    // A page goes back on the list only once nobody references it.
                    if (page_counts[pg] == '0) begin
                        if (32'(stack_top) >= NUM_PAGES) begin
                            o.status = STAT_FULL;
                        end else begin
                            free_pages_stack[stack_top[IDX_W-1:0]] = IDX_W'(pg);
                            stack_top  = stack_top + DEPTH_W'(1);
                            free_total = free_total + TALLY_W'(1);
                        end
                    end
                    if (o.status == STAT_OK) begin
                        o.page_refs = page_counts[pg];
                    end
                end
            end
            CMD_INC, CMD_DEC, CMD_SET, CMD_READ: begin
                if (pg >= NUM_PAGES) begin
                    o.status = STAT_BADADDR;
                end else begin
                    if (r.cmd == CMD_INC && page_counts[pg] != COUNT_MAX) begin
                        page_counts[pg] = page_counts[pg] + COUNT_WIDTH'(1);
                    end else if (r.cmd == CMD_DEC && page_counts[pg] != '0) begin
                        page_counts[pg] = page_counts[pg] - COUNT_WIDTH'(1);
                    end else if (r.cmd == CMD_SET) begin
                        page_counts[pg] = (r.ref_value > COUNT_MAX) ? COUNT_MAX
                                                                    : COUNT_WIDTH'(r.ref_value);
                    end
                    o.page_refs = page_counts[pg];
                end
            end
            default: begin
            end
        endcase
        managed      = (32'(low_page) < NUM_PAGES) ? NUM_PAGES - 32'(low_page) : 0;
        o.free_count = free_total;
        o.used_count = (managed < 32'(free_total)) ? '0
                                                    : TALLY_W'(managed - 32'(free_total));
        return o;
    endfunction

    function automatic t_req mk_req(input logic [2:0] c, input logic [PAGE_W-1:0] pg,
                                    input logic [PAGE_SHIFT-1:0] offs,
                                    input logic [VAL_W-1:0] val);
        t_req r;
        r.cmd       = c;
        r.phys_addr = {pg, offs};
        r.ref_value = val;
        return r;
    endfunction

    // A page near the bottom of the managed range, a few just below it included.
    function automatic logic [PAGE_W-1:0] pool_page();
        int p;
        p = int'(low_page) + int'($urandom_range(0, 23)) - 2;
        if (p < 0) begin
            p = 0;
        end
        if (p > NUM_PAGES - 1) begin
            p = NUM_PAGES - 1;
        end
        return PAGE_W'(p);
    endfunction

    // Count command on a given page, with offset bits that the block must ignore.
    function automatic t_req count_req(input logic [PAGE_W-1:0] pg);
        logic [2:0]            c;
        logic [PAGE_SHIFT-1:0] offs;
        logic [VAL_W-1:0]      val;
        case ($urandom_range(0, 3))
            0: c = CMD_INC;
            1: c = CMD_DEC;
            2: c = CMD_SET;
            default: c = CMD_READ;
        endcase
        offs = ($urandom_range(0, 2) == 0) ? PAGE_SHIFT'($urandom) : '0;
        val  = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom) : VAL_W'($urandom_range(0, 3));
        return mk_req(c, pg, offs, val);
    endfunction

    function automatic t_req pool_req();
        int                    pick;
        logic [PAGE_SHIFT-1:0] offs;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            offs = ($urandom_range(0, 9) == 0) ? PAGE_SHIFT'($urandom_range(1, 4095)) : '0;
            return mk_req(CMD_FREE, pool_page(), offs, VAL_W'($urandom));
        end else if (pick < 50) begin
            return mk_req(CMD_ALLOC, PAGE_W'($urandom), PAGE_SHIFT'($urandom),
                          VAL_W'($urandom));
        end
        return count_req(pool_page());
    endfunction

    // Offer one request transaction and record its outcome once it is accepted.
    task automatic send_req(input t_req r);
        if (tx_gaps_on) begin
            if (tx_burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                tx_burst_left = $urandom_range(1, 20);
            end
            tx_burst_left--;
        end
        i_in       <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        last_outcome = apply_page_cmd(r);
        page_outcomes.push_back(last_outcome);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (page_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_lowest(input logic [LOW_W-1:0] v);
        wait_idle();
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        low_page = v;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Compare every result transaction with the oldest outstanding outcome.
    always @(posedge i_clk) begin : check_results
        t_rsp want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (page_outcomes.size() == 0) begin
                fail_count++;
                $error("result with no request outstanding: status %0d", o_out.status);
            end else begin
                want = page_outcomes.pop_front();
                check_field("status", 32'(want.status), 32'(o_out.status));
                check_field("page_addr", 32'(want.page_addr), 32'(o_out.page_addr));
                check_field("page_refs", 32'(want.page_refs), 32'(o_out.page_refs));
                check_field("free_count", 32'(want.free_count), 32'(o_out.free_count));
                check_field("used_count", 32'(want.used_count), 32'(o_out.used_count));
            end
        end
    end

    // Field extremes, each command, and the corner cases of alloc and free.
    task automatic test_directed_cases();
        write_lowest(16'd16);
        send_req(mk_req(CMD_ALLOC, '0, '0, '0));
        send_req(mk_req(CMD_READ, '0, '0, '0));
        send_req(mk_req(CMD_SET, 16'd32, '0, 16'hFFFF));
        send_req(mk_req(CMD_INC, 16'd32, 12'hFFF, '0));
        send_req(mk_req(CMD_DEC, 16'd32, 12'h800, '0));
        send_req(mk_req(CMD_READ, 16'd32, '0, 16'hFFFF));
        send_req(mk_req(CMD_FREE, 16'd32, 12'h001, '0));
        send_req(mk_req(CMD_FREE, 16'd5, '0, '0));
        send_req(mk_req(CMD_FREE, 16'd16, '0, '0));
        send_req(mk_req(CMD_FREE, 16'hFFFF, '0, '0));
        send_req(mk_req(CMD_FREE, 16'd32, '0, '0));
        // Seeding, and a second free of a page that is already free.
        send_req(mk_req(CMD_SET, 16'd64, '0, '0));
        send_req(mk_req(CMD_FREE, 16'd64, '0, '0));
        send_req(mk_req(CMD_FREE, 16'd64, '0, '0));
        repeat (5) send_req(mk_req(CMD_ALLOC, '0, '0, '0));
        send_req(mk_req(CMD_DEC, 16'd80, '0, '0));
        send_req(mk_req(CMD_INC, 16'd80, '0, '0));
        send_req(mk_req(CMD_SET, 16'd80, 12'hFFF, 16'h1234));
        send_req(mk_req(CMD_READ, 16'hFFFF, 12'hFFF, '0));
        send_req(mk_req(CMD_SPARE6, 16'hFFFF, 12'hFFF, 16'hFFFF));
        send_req(mk_req(CMD_SPARE7, '0, '0, '0));
        send_req(mk_req(CMD_FREE, 16'hFFFF, '0, '0));
        wait_idle();
    endtask

    // Mostly well-formed page lifecycles with random content, plus some noise.
    task automatic test_random_traffic(input logic [LOW_W-1:0] low, input int n_items,
                                       input bit idle_on);
        int               sent;
        int               pick;
        logic [PAGE_W-1:0] pg;
        write_lowest(low);
        tx_gaps_on  = idle_on;
        rx_stall_on <= idle_on;
        rx_pattern  <= 16'($urandom) & 16'($urandom) | 16'h0001;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                pg = pool_page();
                send_req(mk_req(CMD_SET, pg, '0, '0));
                send_req(mk_req(CMD_FREE, pg, '0, '0));
                sent += 2;
            end else if (pick < 55) begin
                send_req(mk_req(CMD_ALLOC, '0, '0, '0));
                sent++;
                if (last_outcome.status == STAT_OK) begin
                    pg = last_outcome.page_addr[ADDR_W-1:PAGE_SHIFT];
                    repeat ($urandom_range(0, 3)) begin
                        send_req(count_req(pg));
                        sent++;
                    end
                    repeat ($urandom_range(1, 2)) begin
                        send_req(mk_req(CMD_FREE, pg, '0, '0));
                        sent++;
                    end
                end
            end else if (pick < 90) begin
                send_req(pool_req());
                sent++;
            end else begin
                send_req(mk_req(3'($urandom_range(0, 7)), PAGE_W'($urandom),
                                PAGE_SHIFT'($urandom), VAL_W'($urandom)));
                sent++;
            end
        end
        // Sender pauses here until every outstanding result has come back.
        wait_idle();
    endtask

    // The result side holds off for a long time while requests keep coming.
    task automatic test_output_backpressure();
        tx_gaps_on  = 1'b0;
        rx_stall_on <= 1'b0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (400) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (40) send_req(pool_req());
        wait_idle();
    endtask

    // Repeated frees of an unreferenced page, then the used count at the top of the range.
    task automatic test_repeat_free();
        write_lowest('0);
        tx_gaps_on  = 1'b0;
        rx_stall_on <= 1'b0;
        send_req(mk_req(CMD_SET, 16'd100, '0, '0));
        send_req(mk_req(CMD_FREE, 16'd100, '0, '0));
        send_req(mk_req(CMD_FREE, 16'd100, '0, '0));
        send_req(mk_req(CMD_SET, 16'd200, '0, 16'd2));
        send_req(mk_req(CMD_FREE, 16'd200, '0, '0));
        send_req(mk_req(CMD_FREE, 16'd200, '0, '0));
        send_req(mk_req(CMD_READ, 16'd200, '0, '0));
        send_req(mk_req(CMD_ALLOC, '0, '0, '0));
        send_req(mk_req(CMD_FREE, 16'd100, '0, '0));
        send_req(mk_req(CMD_ALLOC, '0, '0, '0));
        // With only one managed page the used count floors at zero.
        write_lowest(16'hFFFF);
        send_req(mk_req(CMD_READ, 16'd100, '0, '0));
        send_req(mk_req(CMD_FREE, 16'hFFFE, '0, '0));
        wait_idle();
    endtask

    initial begin
        foreach (page_counts[k]) begin
            page_counts[k]      = '0;
            free_pages_stack[k] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_random_traffic('0, 150, 1'b1);
        test_random_traffic(16'hFFFF, 80, 1'b1);
        test_random_traffic(LOW_W'($urandom), 150, 1'b1);
        test_random_traffic(16'd3, 150, 1'b0);
        test_random_traffic(16'hFFF0, 100, 1'b1);
        test_random_traffic(16'd40, 100, 1'b1);
        test_output_backpressure();
        test_repeat_free();
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #12_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/rpfa_pkg.sv
rtl/refcounted_page_frame_allocator_top.sv
dv/testbench.sv
